[rtl/segment_intersection_point_macros.svh]
// Assertion macros shared by the segment intersection checker.
`ifndef SEGMENT_INTERSECTION_POINT_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_MACROS_SVH

// Checked only outside reset.
`define SIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SIP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/sip_pkg.sv]
// Package with widths and transaction types of the segment intersection block.
`default_nettype none
package sip_pkg;
    localparam int CW  = 16;          // coordinate width
    localparam int DW  = CW + 1;      // coordinate difference width
    localparam int PW  = 2 * DW + 1;  // cross product width, signed
    localparam int NW  = 3 * CW + 3;  // rounding numerator width
    localparam int QW  = CW + 1;      // quotient width
    localparam int FQ  = 4;           // front queue depth
    localparam int FAW = $clog2(FQ);
    localparam int OQ  = 32;          // result queue depth
    localparam int OAW = $clog2(OQ);

    typedef struct packed {
        logic signed [CW-1:0] seg_a_x1;
        logic signed [CW-1:0] seg_a_y1;
        logic signed [CW-1:0] seg_a_x2;
        logic signed [CW-1:0] seg_a_y2;
        logic signed [CW-1:0] seg_b_x1;
        logic signed [CW-1:0] seg_b_y1;
        logic signed [CW-1:0] seg_b_x2;
        logic signed [CW-1:0] seg_b_y2;
    } t_item;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] cross_x;
        logic signed [CW-1:0] cross_y;
    } t_result;

    // Classified pair handed from the front to the back.
    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] ax1;
        logic signed [CW-1:0] ay1;
        logic signed [DW-1:0] rx;
        logic signed [DW-1:0] ry;
        logic [PW-2:0]        tn;
        logic [PW-2:0]        den;
    } t_work;
endpackage
`default_nettype wire

[rtl/sip_front.sv]
// Front part: accepts segment pairs, forms cross products and classifies hits.
`default_nettype none
module sip_front import sip_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    output logic       o_full,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_avail,
    output t_work      o_work
);
    logic                 r_v1, r_v2;
    logic signed [CW-1:0] r_ax1, r_ay1, r_ax1_2, r_ay1_2;
    logic signed [DW-1:0] r_rx, r_ry, r_sx, r_sy, r_qx, r_qy, r_rx2, r_ry2;
    logic signed [PW-1:0] r_den, r_tn, r_un;
    logic signed [2*DW-1:0] m_rs1, m_rs2, m_qs1, m_qs2, m_qr1, m_qr2;
    logic signed [PW-1:0] d_abs, t_abs, u_abs;
    logic                 neg, hit, pushing, taking;
    t_work                r_q [FQ];
    logic [FAW-1:0]       r_wp, r_rp;
    logic [FAW:0]         r_qcnt, r_cnt;

    assign pushing = i_push && !o_full;
    assign taking  = i_take && o_avail;
    assign o_full  = (r_cnt == (FAW+1)'(FQ));
    assign o_avail = (r_qcnt != '0);
    assign o_work  = r_q[r_rp];

    // Stage one: direction vectors and offset between the start points.
    always_ff @(posedge i_clk) begin
        r_ax1 <= i_item.seg_a_x1;
        r_ay1 <= i_item.seg_a_y1;
        r_rx  <= {i_item.seg_a_x2[CW-1], i_item.seg_a_x2} - {i_item.seg_a_x1[CW-1], i_item.seg_a_x1};
        r_ry  <= {i_item.seg_a_y2[CW-1], i_item.seg_a_y2} - {i_item.seg_a_y1[CW-1], i_item.seg_a_y1};
        r_sx  <= {i_item.seg_b_x2[CW-1], i_item.seg_b_x2} - {i_item.seg_b_x1[CW-1], i_item.seg_b_x1};
        r_sy  <= {i_item.seg_b_y2[CW-1], i_item.seg_b_y2} - {i_item.seg_b_y1[CW-1], i_item.seg_b_y1};
        r_qx  <= {i_item.seg_b_x1[CW-1], i_item.seg_b_x1} - {i_item.seg_a_x1[CW-1], i_item.seg_a_x1};
        r_qy  <= {i_item.seg_b_y1[CW-1], i_item.seg_b_y1} - {i_item.seg_a_y1[CW-1], i_item.seg_a_y1};
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= pushing;
        end
    end

    // Stage two: the three cross products.
    always_comb begin
        m_rs1 = r_rx * r_sy;
        m_rs2 = r_ry * r_sx;
        m_qs1 = r_qx * r_sy;
        m_qs2 = r_qy * r_sx;
        m_qr1 = r_qx * r_ry;
        m_qr2 = r_qy * r_rx;
    end

    always_ff @(posedge i_clk) begin
        r_den   <= {m_rs1[2*DW-1], m_rs1} - {m_rs2[2*DW-1], m_rs2};
        r_tn    <= {m_qs1[2*DW-1], m_qs1} - {m_qs2[2*DW-1], m_qs2};
        r_un    <= {m_qr1[2*DW-1], m_qr1} - {m_qr2[2*DW-1], m_qr2};
        r_ax1_2 <= r_ax1;
        r_ay1_2 <= r_ay1;
        r_rx2   <= r_rx;
        r_ry2   <= r_ry;
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    // Sign normalization and the exact range test on t and u.
    always_comb begin
        neg   = r_den[PW-1];
        d_abs = neg ? -r_den : r_den;
        t_abs = neg ? -r_tn : r_tn;
        u_abs = neg ? -r_un : r_un;
        hit   = (r_den != '0) && !t_abs[PW-1] && !u_abs[PW-1]
                && (t_abs <= d_abs) && (u_abs <= d_abs);
    end

    // Queue toward the back part; credits count pairs in flight and queued.
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_q[r_wp].hit <= hit;
            r_q[r_wp].ax1 <= r_ax1_2;
            r_q[r_wp].ay1 <= r_ay1_2;
            r_q[r_wp].rx  <= r_rx2;
            r_q[r_wp].ry  <= r_ry2;
            r_q[r_wp].tn  <= t_abs[PW-2:0];
            r_q[r_wp].den <= d_abs[PW-2:0];
        end
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
            r_cnt  <= '0;
        end else begin
            if (r_v2) begin
                r_wp <= r_wp + 1'b1;
            end
            if (taking) begin
                r_rp <= r_rp + 1'b1;
            end
            r_qcnt <= r_qcnt + (FAW+1)'(r_v2) - (FAW+1)'(taking);
            r_cnt  <= r_cnt + (FAW+1)'(pushing) - (FAW+1)'(taking);
        end
    end
endmodule
`default_nettype wire

[rtl/sip_back.sv]
// Back part: scales t by the direction, divides with rounding and queues results.
`default_nettype none
module sip_back import sip_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_avail,
    output logic       o_take,
    input  wire t_work i_work,
    output logic       o_empty,
    input  wire logic  i_pop,
    output t_result    o_result
);
    typedef struct packed {
        logic                 v;
        logic                 hit;
        logic                 negx;
        logic                 negy;
        logic signed [CW-1:0] ax1;
        logic signed [CW-1:0] ay1;
        logic [NW-1:0]        remx;
        logic [NW-1:0]        remy;
        logic [QW-1:0]        qx;
        logic [QW-1:0]        qy;
        logic [PW-1:0]        dvs;
    } t_div;

    t_div                 r_st [QW+1];
    t_div                 n_st [QW+1];
    logic [CW-1:0]        magx, magy;
    logic [CW+PW-2:0]     px, py;
    logic signed [CW-1:0] resx, resy;
    t_result              r_oq [OQ];
    logic [OAW-1:0]       r_wp, r_rp;
    logic [OAW:0]         r_ocnt, r_cnt;
    logic                 popping;
    t_div                 last;

    assign o_take   = i_avail && (r_cnt < (OAW+1)'(OQ));
    assign popping  = i_pop && !o_empty;
    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_oq[r_rp];

    // Multiply stage: rounding numerator 2*|r|*tn + den over divisor 2*den.
    always_comb begin
        magx = CW'(i_work.rx[DW-1] ? -i_work.rx : i_work.rx);
        magy = CW'(i_work.ry[DW-1] ? -i_work.ry : i_work.ry);
        px   = magx * i_work.tn;
        py   = magy * i_work.tn;
        n_st[0].v    = o_take;
        n_st[0].hit  = i_work.hit;
        n_st[0].negx = i_work.rx[DW-1];
        n_st[0].negy = i_work.ry[DW-1];
        n_st[0].ax1  = i_work.ax1;
        n_st[0].ay1  = i_work.ay1;
        n_st[0].remx = {px, 1'b0} + NW'(i_work.den);
        n_st[0].remy = {py, 1'b0} + NW'(i_work.den);
        n_st[0].qx   = '0;
        n_st[0].qy   = '0;
        n_st[0].dvs  = {i_work.den, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st[0];
        if (!i_rst_n) begin
            r_st[0].v <= 1'b0;
        end
    end

    // Restoring division, one quotient bit per stage, both coordinates at once.
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int B = QW - 1 - k;
        logic [NW-1:0] sh;
        logic          gex, gey;

        always_comb begin
            sh         = NW'(r_st[k].dvs) << B;
            gex        = (r_st[k].remx >= sh);
            gey        = (r_st[k].remy >= sh);
            n_st[k+1]  = r_st[k];
            n_st[k+1].remx = gex ? r_st[k].remx - sh : r_st[k].remx;
            n_st[k+1].remy = gey ? r_st[k].remy - sh : r_st[k].remy;
            n_st[k+1].qx[B] = gex;
            n_st[k+1].qy[B] = gey;
        end

        always_ff @(posedge i_clk) begin
            r_st[k+1] <= n_st[k+1];
            if (!i_rst_n) begin
                r_st[k+1].v <= 1'b0;
            end
        end
    end

    // Final point: start point plus or minus the rounded offset.
    always_comb begin
        last = r_st[QW];
        resx = last.negx ? last.ax1 - last.qx[CW-1:0] : last.ax1 + last.qx[CW-1:0];
        resy = last.negy ? last.ay1 - last.qy[CW-1:0] : last.ay1 + last.qy[CW-1:0];
    end

    // Result queue; credits cover pairs in the pipeline and results queued.
    always_ff @(posedge i_clk) begin
        if (last.v) begin
            r_oq[r_wp].hit     <= last.hit;
            r_oq[r_wp].cross_x <= last.hit ? resx : '0;
            r_oq[r_wp].cross_y <= last.hit ? resy : '0;
        end
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_ocnt <= '0;
            r_cnt  <= '0;
        end else begin
            if (last.v) begin
                r_wp <= r_wp + 1'b1;
            end
            if (popping) begin
                r_rp <= r_rp + 1'b1;
            end
            r_ocnt <= r_ocnt + (OAW+1)'(last.v) - (OAW+1)'(popping);
            r_cnt  <= r_cnt + (OAW+1)'(o_take) - (OAW+1)'(popping);
        end
    end
endmodule
`default_nettype wire

[rtl/segment_intersection_point.sv]
// Top level of the two-segment intersection point block.
//
// Each input transaction carries two segments A and B as signed 16-bit end
// points; each result transaction carries a hit flag and the crossing point,
// rounded to nearest, with zero coordinates when there is no hit.
// Input side is a queue write port: a transaction is taken on a clock edge
// with push high and full low. Result side is a queue read port: the oldest
// result is shown while empty is low and leaves on an edge with pop high.
// A new pair can enter every cycle while full is low. On the way from push
// to empty going low, a pair passes two front stages (differences, cross
// products), the front queue, one multiply stage and one stage per quotient
// bit (17) of the rounding divider, then the result queue.
// The result queue holds 32 results. When the receiver stops popping, the
// back part stops pulling from the front queue once its credits run out,
// and full rises when the four front slots are taken; nothing is dropped.
// Synchronous reset empties both queues and the pipelines.
`default_nettype none
module segment_intersection_point import sip_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire t_item i_item,
    output logic       empty,
    input  wire logic  pop,
    output t_result    o_result
);
    logic  take, avail;
    t_work work;

    // Front part: accept and classify.
    sip_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .i_take  (take),
        .o_avail (avail),
        .o_work  (work)
    );

    // Back part: point computation and result queue.
    sip_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (avail),
        .o_take   (take),
        .i_work   (work),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );
endmodule
`default_nettype wire

[rtl/sip_checker.sv]
// Port-level checker for the segment intersection block, with its bind.
`default_nettype none
`include "segment_intersection_point_macros.svh"
module sip_checker import sip_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    push,
    input wire logic    full,
    input wire logic    empty,
    input wire logic    pop,
    input wire t_result o_result
);
    // A miss never carries a point.
    `SIP_ASSERT(a_miss_zero, (!empty && !o_result.hit) |-> (o_result.cross_x == '0 && o_result.cross_y == '0), "miss with nonzero point")
    // Reset leaves both queues empty.
    `SIP_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> (empty && !full), "queues not empty after reset")
    // A result nobody takes stays in place.
    `SIP_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(o_result)), "stalled result changed")
    // Input is only held off when the back part has backed up, so results are waiting.
    `SIP_ASSERT(a_no_early, (push && full) |-> !empty, "input held off with no results waiting")
endmodule

bind segment_intersection_point sip_checker u_sip_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
`default_nettype wire
